// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// clocked checks on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ise_pkg.sv =====
// ---------------------------------------------------------------------------
// ise_pkg
// shared widths, codes, command and status types and the iupac mask table
// ---------------------------------------------------------------------------
package ise_pkg;

    localparam int MAX_SEQ_LEN = 4096;
    localparam int ADDR_W      = $clog2(MAX_SEQ_LEN);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int OP_W        = 2;
    localparam int CHAR_W      = 8;
    localparam int POS_W       = 13;
    localparam int STAT_W      = 2;
    localparam int SUM_W       = (CNT_W > POS_W) ? CNT_W + 1 : POS_W + 1;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND_Q = 2'd0,
        OP_APPEND_T = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_EXTEND   = 2'd3
    } ise_op_t;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    localparam logic [3:0] BASE_A = 4'b0001;
    localparam logic [3:0] BASE_C = 4'b0010;
    localparam logic [3:0] BASE_G = 4'b0100;
    localparam logic [3:0] BASE_T = 4'b1000;

    typedef struct packed {
        logic in_ready;
        logic take_simple;
        logic take_extend;
        logic check;
        logic walk;
        logic start_right;
        logic finish;
    } ise_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_extend;
        logic out_free;
        logic bad;
        logic walk_done;
    } ise_stat_t;

    function automatic logic [3:0] base_mask(input logic [CHAR_W-1:0] c);
        logic [3:0] m;
        case (c)
            "A":     m = BASE_A;
            "C":     m = BASE_C;
            "G":     m = BASE_G;
            "T":     m = BASE_T;
            "U":     m = BASE_T;
            "Y":     m = BASE_C | BASE_T;
            "R":     m = BASE_G | BASE_A;
            "S":     m = BASE_C | BASE_G;
            "W":     m = BASE_A | BASE_T;
            "K":     m = BASE_G | BASE_T;
            "M":     m = BASE_A | BASE_C;
            "B":     m = BASE_C | BASE_G | BASE_T;
            "D":     m = BASE_A | BASE_G | BASE_T;
            "H":     m = BASE_A | BASE_C | BASE_T;
            "V":     m = BASE_A | BASE_C | BASE_G;
            "N":     m = BASE_A | BASE_C | BASE_G | BASE_T;
            default: m = 4'b0000;
        endcase
        return m;
    endfunction

endpackage

// ===== sv/ise_in_if.sv =====
// ---------------------------------------------------------------------------
// ise_in_if
// request channel: op, sequence byte and seed coordinates
// ---------------------------------------------------------------------------
interface ise_in_if;
    import ise_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  query_pos;
    logic [POS_W-1:0]  query_seed_len;
    logic [POS_W-1:0]  target_pos;
    logic [POS_W-1:0]  target_seed_len;

    modport source (
        output valid, op, char_code, query_pos, query_seed_len, target_pos,
               target_seed_len,
        input  ready
    );

    modport sink (
        input  valid, op, char_code, query_pos, query_seed_len, target_pos,
               target_seed_len,
        output ready
    );
endinterface

// ===== sv/ise_out_if.sv =====
// ---------------------------------------------------------------------------
// ise_out_if
// response channel: extension lengths and status
// ---------------------------------------------------------------------------
interface ise_out_if;
    import ise_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  left_len;
    logic [POS_W-1:0]  right_len;
    logic [STAT_W-1:0] status;

    modport source (
        output valid, left_len, right_len, status,
        input  ready
    );

    modport sink (
        input  valid, left_len, right_len, status,
        output ready
    );
endinterface

// ===== sv/ise_ctrl.sv =====
// ---------------------------------------------------------------------------
// ise_ctrl
// sequencer: takes words, runs bound check, then left and right walk for an in-bounds seed, response
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ise_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  ise_pkg::ise_stat_t st,
    output ise_pkg::ise_cmd_t  cmd
);
    import ise_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_LEFT   = 5'b00100,
        S_RIGHT  = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = st.out_free;
                if (st.in_valid && st.out_free)
                begin
                    if (st.in_extend)
                    begin
                        cmd.take_extend = 1'b1;
                        state_next      = S_CHECK;
                    end
                    else
                    begin
                        cmd.take_simple = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = st.bad ? S_FINISH : S_LEFT;
            end
            S_LEFT:
            begin
                if (st.walk_done)
                begin
                    cmd.start_right = 1'b1;
                    state_next      = S_RIGHT;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_RIGHT:
            begin
                if (st.walk_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.walk = 1'b1;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `ASSERT_NEXT(a_extend_to_check, (state_reg == S_IDLE) && st.in_valid && st.out_free && st.in_extend, state_reg == S_CHECK, "extend word did not start a bound check")
    `ASSERT_NEXT(a_finish_to_idle, (state_reg == S_FINISH) && st.out_free, state_reg == S_IDLE, "response not issued from finish")

endmodule

// ===== sv/ise_datapath.sv =====
// ---------------------------------------------------------------------------
// ise_datapath
// sequence memories, fill counts, seed registers, walk counter, response reg
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ise_datapath (
    input  logic               clk,
    input  logic               rst_n,
    ise_in_if.sink             req,
    ise_out_if.source          rsp,
    input  ise_pkg::ise_cmd_t  cmd,
    output ise_pkg::ise_stat_t st
);
    import ise_pkg::*;

    logic [CHAR_W-1:0] qmem [MAX_SEQ_LEN];
    logic [CHAR_W-1:0] tmem [MAX_SEQ_LEN];

    logic [CNT_W-1:0]  qcount_reg, qcount_next;
    logic [CNT_W-1:0]  tcount_reg, tcount_next;
    logic              out_valid_reg, out_valid_next;
    logic              pend_reg, pend_next;
    logic              bad_reg, bad_next;
    logic              dir_right_reg, dir_right_next;

    logic [POS_W-1:0]  qpos_reg, tpos_reg;
    logic [SUM_W-1:0]  qend_reg, tend_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  lim_reg, lim_next;
    logic [CNT_W-1:0]  rlim_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [CHAR_W-1:0] qrd_reg, trd_reg;
    logic [POS_W-1:0]  out_left_reg, out_right_reg;
    logic [STAT_W-1:0] out_status_reg;

    logic              q_full, t_full, q_we, t_we;
    logic              bad, compat, out_free, load_out;
    logic [CNT_W-1:0]  cnt_inc, rd_idx, q_rem, t_rem;
    logic [POS_W-1:0]  lmax;
    logic [SUM_W-1:0]  q_raddr_w, t_raddr_w;
    logic [STAT_W-1:0] simple_status;

    assign q_full = qcount_reg >= CNT_W'(MAX_SEQ_LEN);
    assign t_full = tcount_reg >= CNT_W'(MAX_SEQ_LEN);
    assign q_we   = cmd.take_simple && (req.op == OP_APPEND_Q) && !q_full;
    assign t_we   = cmd.take_simple && (req.op == OP_APPEND_T) && !t_full;

    assign simple_status = (((req.op == OP_APPEND_Q) && q_full) ||
                            ((req.op == OP_APPEND_T) && t_full)) ? ST_FULL : ST_OK;

    assign bad  = (qend_reg > SUM_W'(qcount_reg)) || (tend_reg > SUM_W'(tcount_reg));
    assign lmax = (qpos_reg < tpos_reg) ? qpos_reg : tpos_reg;
    assign q_rem = qcount_reg - CNT_W'(qend_reg);
    assign t_rem = tcount_reg - CNT_W'(tend_reg);

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign rd_idx  = pend_reg ? cnt_inc : cnt_reg;

    // left walk reads below the seed start, right walk reads past the seed end
    assign q_raddr_w = dir_right_reg ? (qend_reg + SUM_W'(rd_idx))
                                     : (SUM_W'(qpos_reg) - SUM_W'(rd_idx) - SUM_W'(1));
    assign t_raddr_w = dir_right_reg ? (tend_reg + SUM_W'(rd_idx))
                                     : (SUM_W'(tpos_reg) - SUM_W'(rd_idx) - SUM_W'(1));

    assign compat = (qrd_reg == trd_reg) || ((base_mask(qrd_reg) & base_mask(trd_reg)) != 4'b0000);

    assign out_free = !out_valid_reg || rsp.ready;
    assign load_out = cmd.take_simple || cmd.finish;

    assign st.in_valid  = req.valid;
    assign st.in_extend = (req.op == OP_EXTEND);
    assign st.out_free  = out_free;
    assign st.bad       = bad;
    assign st.walk_done = (!pend_reg && !(cnt_reg < lim_reg)) || (pend_reg && !compat);

    assign req.ready     = cmd.in_ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.left_len  = out_left_reg;
    assign rsp.right_len = out_right_reg;
    assign rsp.status    = out_status_reg;

    always_comb
    begin
        qcount_next    = qcount_reg;
        tcount_next    = tcount_reg;
        pend_next      = pend_reg;
        bad_next       = bad_reg;
        dir_right_next = dir_right_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        out_valid_next = out_valid_reg;

        if (q_we)
        begin
            qcount_next = qcount_reg + CNT_W'(1);
        end
        if (t_we)
        begin
            tcount_next = tcount_reg + CNT_W'(1);
        end
        if (cmd.take_simple && (req.op == OP_CLEAR))
        begin
            qcount_next = '0;
            tcount_next = '0;
        end

        if (cmd.check)
        begin
            bad_next       = bad;
            cnt_next       = '0;
            pend_next      = 1'b0;
            lim_next       = CNT_W'(lmax);
            dir_right_next = 1'b0;
        end

        if (cmd.start_right)
        begin
            cnt_next       = '0;
            pend_next      = 1'b0;
            lim_next       = rlim_reg;
            dir_right_next = 1'b1;
        end

        if (cmd.walk)
        begin
            if (!pend_reg)
            begin
                pend_next = cnt_reg < lim_reg;
            end
            else if (compat)
            begin
                cnt_next  = cnt_inc;
                pend_next = cnt_inc < lim_reg;
            end
        end

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg    <= '0;
            tcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            bad_reg       <= 1'b0;
            dir_right_reg <= 1'b0;
        end
        else
        begin
            qcount_reg    <= qcount_next;
            tcount_reg    <= tcount_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            bad_reg       <= bad_next;
            dir_right_reg <= dir_right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        lim_reg <= lim_next;
        if (cmd.take_extend)
        begin
            qpos_reg <= req.query_pos;
            tpos_reg <= req.target_pos;
            qend_reg <= SUM_W'(req.query_pos) + SUM_W'(req.query_seed_len);
            tend_reg <= SUM_W'(req.target_pos) + SUM_W'(req.target_seed_len);
        end
        if (cmd.check)
        begin
            rlim_reg <= (q_rem < t_rem) ? q_rem : t_rem;
        end
        if (cmd.start_right)
        begin
            left_reg <= cnt_reg;
        end
        if (load_out)
        begin
            if (cmd.take_simple)
            begin
                out_left_reg   <= '0;
                out_right_reg  <= '0;
                out_status_reg <= simple_status;
            end
            else if (bad_reg)
            begin
                out_left_reg   <= '0;
                out_right_reg  <= '0;
                out_status_reg <= ST_BAD;
            end
            else
            begin
                out_left_reg   <= POS_W'(left_reg);
                out_right_reg  <= POS_W'(cnt_reg);
                out_status_reg <= ST_OK;
            end
        end
    end

    // sequence memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            qmem[qcount_reg[ADDR_W-1:0]] <= req.char_code;
        end
        if (t_we)
        begin
            tmem[tcount_reg[ADDR_W-1:0]] <= req.char_code;
        end
        qrd_reg <= qmem[q_raddr_w[ADDR_W-1:0]];
        trd_reg <= tmem[t_raddr_w[ADDR_W-1:0]];
    end

    `ASSERT_IMPL(a_pend_in_range, pend_reg, cnt_reg < lim_reg, "read outstanding past walk limit")
    `ASSERT_HOLDS(a_count_bound, (qcount_reg <= CNT_W'(MAX_SEQ_LEN)) && (tcount_reg <= CNT_W'(MAX_SEQ_LEN)), "fill count beyond capacity")
    `ASSERT_IMPL(a_load_when_free, load_out, out_free, "response register overwritten")

endmodule

// ===== sv/iupac_seed_extension.sv =====
// ---------------------------------------------------------------------------
// iupac_seed_extension
// ungapped seed extension over iupac nucleotide codes
// ---------------------------------------------------------------------------
// Append and clear words can follow back to back while the response register is
// free; every word gives one response word. An extend word runs a bound check,
// then, for a seed inside the loaded data, walks left and then right, each
// direction walking one character pair per cycle through the single registered
// read port of the query and target memories, and then posts the response once
// the response register is free.
// Both buffers hold 4096 bytes and need no clearing after reset.
module iupac_seed_extension (
    input  logic      clk,
    input  logic      rst_n,
    ise_in_if.sink    req,
    ise_out_if.source rsp
);
    import ise_pkg::*;

    ise_cmd_t  cmd;
    ise_stat_t st;

    ise_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    ise_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .st    (st)
    );

endmodule
